// ===== rtl/core/depth_background_segmenter_unit_defines.svh =====
// Assertion macros for the depth background segmenter.
`ifndef DEPTH_BACKGROUND_SEGMENTER_UNIT_DEFINES_SVH
`define DEPTH_BACKGROUND_SEGMENTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DBS_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DBS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DBS_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define DBS_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ===== rtl/core/dbs_pkg.sv =====
package dbs_pkg;

  typedef struct packed {
    logic        action;
    logic [15:0] depth_in;
    logic [8:0]  pixel_row;
    logic [9:0]  pixel_col;
  } dbs_in_t;

  typedef struct packed {
    logic [15:0] depth_out;
    logic        is_foreground;
  } dbs_out_t;

  typedef enum logic [2:0] {
    REG_X_COL   = 3'd0,
    REG_X_ROW   = 3'd1,
    REG_X_CONST = 3'd2,
    REG_X_OFF   = 3'd3,
    REG_Z_COL   = 3'd4,
    REG_Z_ROW   = 3'd5,
    REG_Z_CONST = 3'd6,
    REG_Z_OFF   = 3'd7
  } reg_idx_t;

  localparam logic        ACT_LEARN = 1'b0;
  localparam logic [7:0]  COUNT_MAX = 8'd255;
  localparam int          FRAC_BITS = 28;
  localparam logic signed [63:0] X_LO = -64'sd2500 <<< FRAC_BITS;
  localparam logic signed [63:0] X_HI = 64'sd2500 <<< FRAC_BITS;
  localparam logic signed [63:0] Z_LO = 64'sd600 <<< FRAC_BITS;
  localparam logic signed [63:0] Z_HI = 64'sd1400 <<< FRAC_BITS;
  localparam logic [19:0] NOISE_NUM = 20'd625000;
  localparam logic [2:0]  NOISE_DEN = 3'd7;

  // Partial state of the long division of the rounded sum by the count.
  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] low;
    logic [15:0] quo;
    logic [7:0]  div;
  } dv_t;

  // Four restoring-division steps: one quotient bit each.
  function automatic dv_t div_step(dv_t s);
    dv_t        r;
    logic [8:0] t;
    r = s;
    for (int i = 0; i < 4; i++) begin
      t = {r.rem, r.low[15]};
      r.low = {r.low[14:0], 1'b0};
      if (t >= {1'b0, r.div}) begin
        r.rem = 8'(t - {1'b0, r.div});
        r.quo = {r.quo[14:0], 1'b1};
      end else begin
        r.rem = t[7:0];
        r.quo = {r.quo[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/depth_background_segmenter_unit.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      in_valid / in_ready        dbs_in_t   (one pixel)
// out       output     out_valid / out_ready      dbs_out_t  (segment results only)
// cfg       input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One pixel enters per cycle while the output register is free and the store is not
// clearing. A segment result passes address, store read, four divider stages with
// depth-by-ray multiply chain beside them, two noise-test stages and output register.
// After reset the pixel store is cleared one entry a cycle, all ROWS*COLS entries,
// with in_ready low; configuration writes are taken throughout.
// The whole pipeline advances together whenever the output register is free.
`include "depth_background_segmenter_unit_defines.svh"
module depth_background_segmenter_unit
  import dbs_pkg::*;
#(
  parameter int ROWS = 480,
  parameter int COLS = 640
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  dbs_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output dbs_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic signed [31:0] x_col, x_row, x_const, x_off;
  logic signed [31:0] z_col, z_row, z_const, z_off;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_col <= '0; x_row <= '0; x_const <= '0; x_off <= '0;
      z_col <= '0; z_row <= '0; z_const <= '0; z_off <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_X_COL:   x_col   <= cfg_data;
        REG_X_ROW:   x_row   <= cfg_data;
        REG_X_CONST: x_const <= cfg_data;
        REG_X_OFF:   x_off   <= cfg_data;
        REG_Z_COL:   z_col   <= cfg_data;
        REG_Z_ROW:   z_row   <= cfg_data;
        REG_Z_CONST: z_const <= cfg_data;
        REG_Z_OFF:   z_off   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the output register can take data.
  logic adv;
  logic clearing;
  logic [ADDR_W-1:0] clr_addr;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Stage A: register the pixel and its store address.
  logic              a_valid, a_action, a_inside;
  logic [15:0]       a_depth;
  logic [8:0]        a_row;
  logic [9:0]        a_col;
  logic [ADDR_W-1:0] a_idx;
  logic              in_inside;

  assign in_inside = (32'(in_data.pixel_row) < 32'(ROWS)) &&
                     (32'(in_data.pixel_col) < 32'(COLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_action <= in_data.action;
      a_depth  <= in_data.depth_in;
      a_row    <= in_data.pixel_row;
      a_col    <= in_data.pixel_col;
      a_inside <= in_inside;
      a_idx    <= in_inside ?
                  ADDR_W'(ADDR_W'(in_data.pixel_row) * ADDR_W'(COLS)
                          + ADDR_W'(in_data.pixel_col)) : '0;
    end
  end

  // Pixel store: {sum, count} per entry, one write and one read port.
  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  // Stage B: read data arrives, learn items update, segment items set up.
  logic              b_valid, b_action, b_inside;
  logic [15:0]       b_depth;
  logic [8:0]        b_row;
  logic [9:0]        b_col;
  logic [ADDR_W-1:0] b_idx;
  logic              fwd_hit;
  logic [31:0]       fwd_val;
  logic [31:0]       b_entry;
  logic [23:0]       b_sum;
  logic [7:0]        b_cnt;
  logic              b_learn_wr;
  logic [31:0]       b_new;

  assign b_entry    = fwd_hit ? fwd_val : rd_data;
  assign b_sum      = b_entry[31:8];
  assign b_cnt      = b_entry[7:0];
  assign b_learn_wr = b_valid && (b_action == ACT_LEARN) && b_inside &&
                      (b_depth != 16'd0) && (b_cnt != COUNT_MAX);
  assign b_new      = {b_sum + 24'(b_depth), b_cnt + 8'd1};

  assign wr_en   = clearing || (adv && b_learn_wr);
  assign wr_addr = clearing ? clr_addr : b_idx;
  assign wr_data = clearing ? 32'd0 : b_new;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= mem[a_idx];
    end
  end

  // A learn write in B lands on the same edge that A reads; forward it.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
      fwd_hit <= b_learn_wr && a_valid && (b_idx == a_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_val  <= b_new;
      b_action <= a_action;
      b_depth  <= a_depth;
      b_row    <= a_row;
      b_col    <= a_col;
      b_inside <= a_inside;
      b_idx    <= a_idx;
    end
  end

  // Divider set-up: background = (sum + count/2) / count, or 0 if empty or off the image.
  logic [7:0]  b_div_cnt;
  logic [24:0] b_num;
  dv_t         b_dv;

  always_comb begin
    b_div_cnt   = b_inside ? b_cnt : 8'd0;
    b_num       = (b_div_cnt == 8'd0) ? 25'd0 :
                  25'(b_sum) + 25'(b_div_cnt >> 1);
    b_dv.rem    = b_num[23:16];
    b_dv.low    = b_num[15:0];
    b_dv.quo    = '0;
    b_dv.div    = (b_div_cnt == 8'd0) ? 8'd1 : b_div_cnt;
  end

  // Stages D1..D4: four bits of quotient per stage, world x and z in step.
  logic [4:1]         d_valid;
  dv_t                d_dv    [1:4];
  logic [15:0]        d_depth [1:4];
  logic signed [42:0] xp_c, zp_c;
  logic signed [41:0] xp_r, zp_r;
  logic signed [44:0] x_ray, z_ray;
  logic signed [61:0] x_dr, z_dr;
  logic signed [63:0] x_w, z_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= '0;
    end else if (adv) begin
      d_valid <= {d_valid[3:1], b_valid && (b_action != ACT_LEARN)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_dv[1]    <= div_step(b_dv);
      d_depth[1] <= b_depth;
      for (int s = 2; s <= 4; s++) begin
        d_dv[s]    <= div_step(d_dv[s-1]);
        d_depth[s] <= d_depth[s-1];
      end
      xp_c  <= x_col * $signed({1'b0, b_col});
      xp_r  <= x_row * $signed({1'b0, b_row});
      zp_c  <= z_col * $signed({1'b0, b_col});
      zp_r  <= z_row * $signed({1'b0, b_row});
      x_ray <= 45'(xp_c) + 45'(xp_r) + 45'(x_const);
      z_ray <= 45'(zp_c) + 45'(zp_r) + 45'(z_const);
      x_dr  <= x_ray * $signed({1'b0, d_depth[2]});
      z_dr  <= z_ray * $signed({1'b0, d_depth[2]});
      x_w   <= 64'(x_dr) + (64'(x_off) <<< FRAC_BITS);
      z_w   <= 64'(z_dr) + (64'(z_off) <<< FRAC_BITS);
    end
  end

  // Stage E: box test and the two noise-test products' first halves.
  logic        e_valid, f_valid;
  logic        e_box, f_box;
  logic [15:0] e_depth, f_depth;
  logic [15:0] e_diff;
  logic [31:0] e_bgsq;
  logic [36:0] f_lhs, f_rhs;
  logic [15:0] d4_bg;

  assign d4_bg = d_dv[4].quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid[4];
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_depth <= d_depth[4];
      e_box   <= (x_w > X_LO) && (x_w < X_HI) && (z_w > Z_LO) && (z_w < Z_HI);
      e_diff  <= (d4_bg > d_depth[4]) ? d4_bg - d_depth[4] : d_depth[4] - d4_bg;
      e_bgsq  <= 32'(d4_bg) * 32'(d4_bg);
      f_depth <= e_depth;
      f_box   <= e_box;
      f_lhs   <= 37'(NOISE_NUM) * 37'(e_diff);
      f_rhs   <= 37'(NOISE_DEN) * 37'(e_bgsq);
    end
  end

  // Output register.
  logic out_fg;
  assign out_fg = f_box && (f_lhs > f_rhs);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.depth_out     <= out_fg ? f_depth : 16'd0;
      out_data.is_foreground <= out_fg;
    end
  end

  // A learn write never collides with the clearing sweep.
  `DBS_ASSERT_NOW(a_no_learn_in_clear, clk, rst, b_learn_wr && adv, !clearing)
  // A forwarded entry always belongs to an item in stage B.
  `DBS_ASSERT_NOW(a_fwd_has_item, clk, rst, fwd_hit, b_valid)
  // Nonzero result depth only on a foreground pixel.
  `DBS_ASSERT_NOW(a_depth_means_fg, clk, rst,
                  out_valid && (out_data.depth_out != 16'd0),
                  out_data.is_foreground)

endmodule

// ===== sim/tb_depth_background_segmenter_unit.sv =====
module tb_depth_background_segmenter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dbs_pkg::*;

  localparam int ROWS = 480;
  localparam int COLS = 640;
  localparam int PIXELS = ROWS * COLS;
  localparam logic ACT_SEGMENT = ~ACT_LEARN;
  // After reset the store clears all ROWS*COLS entries, so the limit starts
  // from that and leaves a wide margin for idling, stalls and the long hold.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  dbs_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  dbs_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  depth_background_segmenter_unit #(.ROWS(ROWS), .COLS(COLS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Pixels waiting to be offered, and segment results the block still owes us.
  dbs_in_t  pixel_queue[$];
  dbs_out_t owed_results[$];

  // Our own copy of the block's state: the learned background per pixel and
  // the eight affine registers, kept as sign-extended 64-bit values.
  logic [23:0] bg_sum[PIXELS];
  logic [7:0]  bg_count[PIXELS];
  longint      coeff[8];

  int  mismatches = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  bit  no_idle = 0;
  bit  in_taken = 0;
  bit  hold_done = 0;
  int  hold_left = 0;

  // Hot pixels that the random stream keeps returning to, with the depth
  // each one tends to see. The first entry gets most traffic so that its
  // count runs into saturation.
  logic [8:0]  hot_row[4] = '{9'd0, 9'd479, 9'd100, 9'd240};
  logic [9:0]  hot_col[4] = '{10'd0, 10'd639, 10'd321, 10'd512};
  int          hot_depth[4] = '{1000, 700, 1350, 3000};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Updates the background copy for a learn pixel, or works out the result
  // of a segment pixel and queues it.
  task automatic segment_or_learn(input dbs_in_t px);
    bit       in_image;
    int       idx;
    longint   bg, diff, d, ray_x, ray_z, wx, wz;
    bit       fg;
    dbs_out_t res;
    in_image = (px.pixel_row < ROWS) && (px.pixel_col < COLS);
    idx = in_image ? px.pixel_row * COLS + px.pixel_col : 0;
    d = px.depth_in;
    if (px.action == ACT_LEARN) begin
      // Zero depths, pixels outside the image and full counts leave the entry.
      if (in_image && d != 0 && bg_count[idx] < COUNT_MAX) begin
        bg_sum[idx] = bg_sum[idx] + px.depth_in;
        bg_count[idx] = bg_count[idx] + 8'd1;
      end
      return;
    end
    bg = 0;
    if (in_image && bg_count[idx] != 0)
      bg = (longint'(bg_sum[idx]) + bg_count[idx] / 2) / bg_count[idx];
    diff = (bg > d) ? bg - d : d - bg;
    ray_x = coeff[REG_X_COL] * px.pixel_col + coeff[REG_X_ROW] * px.pixel_row
          + coeff[REG_X_CONST];
    ray_z = coeff[REG_Z_COL] * px.pixel_col + coeff[REG_Z_ROW] * px.pixel_row
          + coeff[REG_Z_CONST];
    wx = d * ray_x + (coeff[REG_X_OFF] <<< FRAC_BITS);
    wz = d * ray_z + (coeff[REG_Z_OFF] <<< FRAC_BITS);
    fg = (625000 * diff > 7 * bg * bg) && (wx > X_LO) && (wx < X_HI)
      && (wz > Z_LO) && (wz < Z_HI);
    res.depth_out = fg ? px.depth_in : 16'd0;
    res.is_foreground = fg;
    owed_results = {owed_results, res};
  endtask

  // Input driver. Acceptance is seen at the rising edge; the next pixel, or a
  // random idle cycle, is set up at the falling edge. A pixel that was not
  // taken stays on the bus unchanged.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      segment_or_learn(pixel_queue.pop_front());
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!in_valid || in_taken) begin
      next_valid = (pixel_queue.size() > 0) && (no_idle || $urandom_range(99) >= 28);
      if (next_valid)
        in_data <= pixel_queue[0];
    end
    in_taken = 1'b0;
    in_valid <= next_valid;
  end

  // Output side: random back-pressure, plus one long hold-off once enough
  // results have gone by, long enough for the pipeline to fill and stall the
  // input while the driver keeps offering pixels.
  always @(negedge clk) begin
    if (!hold_done && results_seen >= 150) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || $urandom_range(99) >= 28;
    end
  end

  // Result monitor: every transaction is compared with the oldest owed result.
  always @(posedge clk) begin
    dbs_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen = results_seen + 1;
      if (owed_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result: depth_out=%0d is_foreground=%0b",
                   out_data.depth_out, out_data.is_foreground);
      end else begin
        want = owed_results.pop_front();
        if (out_data.depth_out !== want.depth_out
            || out_data.is_foreground !== want.is_foreground) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: depth_out exp %0d got %0d, is_foreground exp %0b got %0b",
                     want.depth_out, out_data.depth_out,
                     want.is_foreground, out_data.is_foreground);
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One register write on the configuration channel; the copy is updated at
  // the edge where the transaction happens.
  task automatic write_coeff(input reg_idx_t which, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    coeff[which] = longint'($signed(value));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every pixel has been taken and every result has come, then
  // lets the pipeline empty, since learn pixels leave no result behind them.
  task automatic wait_idle();
    @(posedge clk);
    while (pixel_queue.size() > 0 || owed_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic dbs_in_t make_pixel(input logic act, input int d,
                                         input int r, input int c);
    dbs_in_t px;
    px.action = act;
    px.depth_in = 16'(d);
    px.pixel_row = 9'(r);
    px.pixel_col = 10'(c);
    return px;
  endfunction

  // Appends one pixel to the pending queue.
  task automatic queue_pixel(input dbs_in_t px);
    pixel_queue = {pixel_queue, px};
  endtask

  // Random pixels: mostly hot pixels near their usual depth, learning or
  // segmenting at random, with some zero depths, wild depths and arbitrary
  // coordinates, including ones off the image.
  task automatic queue_random(input int n);
    int      h, roll, d;
    dbs_in_t px;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      h = (roll < 45) ? 0 : $urandom_range(3);
      roll = $urandom_range(99);
      if (roll < 70)
        d = hot_depth[h] + $urandom_range(60) - 30;
      else if (roll < 78)
        d = 0;
      else
        d = $urandom_range(65535);
      if ($urandom_range(99) < 85)
        px = make_pixel(1'($urandom_range(1)), d, hot_row[h], hot_col[h]);
      else
        px = make_pixel(1'($urandom_range(1)), d, $urandom_range(511),
                        $urandom_range(1023));
      queue_pixel(px);
    end
  endtask

  // Realistic camera: x stays 0 and z equals the depth, so the box passes
  // exactly for depths strictly between 600 and 1400 millimetres.
  task automatic set_straight_camera();
    write_coeff(REG_X_COL, 32'd0);
    write_coeff(REG_X_ROW, 32'd0);
    write_coeff(REG_X_CONST, 32'd0);
    write_coeff(REG_X_OFF, 32'd0);
    write_coeff(REG_Z_COL, 32'd0);
    write_coeff(REG_Z_ROW, 32'd0);
    write_coeff(REG_Z_CONST, 32'h1000_0000);
    write_coeff(REG_Z_OFF, 32'd0);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < PIXELS; i++) begin
      bg_sum[i] = '0;
      bg_count[i] = '0;
    end
    for (int i = 0; i < 8; i++) coeff[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset registers put z at 0, so nothing can be foreground here; the
    // directed pixels exercise the store's corner cases under that.
    queue_pixel(make_pixel(ACT_SEGMENT, 1000, 5, 5));
    queue_pixel(make_pixel(ACT_LEARN, 65535, 0, 0));
    queue_pixel(make_pixel(ACT_LEARN, 0, 0, 0));
    queue_pixel(make_pixel(ACT_SEGMENT, 65535, 0, 0));
    queue_pixel(make_pixel(ACT_LEARN, 1, 479, 639));
    queue_pixel(make_pixel(ACT_LEARN, 2, 479, 639));
    queue_pixel(make_pixel(ACT_SEGMENT, 0, 479, 639));
    queue_pixel(make_pixel(ACT_LEARN, 900, 480, 640));
    queue_pixel(make_pixel(ACT_SEGMENT, 900, 511, 1023));
    queue_pixel(make_pixel(ACT_SEGMENT, 0, 7, 9));
    wait_idle();

    set_straight_camera();
    // Learned background near 1000 at one pixel, then hits close to it, far
    // from it, at depth zero and outside the box.
    queue_pixel(make_pixel(ACT_LEARN, 1000, 10, 20));
    queue_pixel(make_pixel(ACT_LEARN, 1001, 10, 20));
    queue_pixel(make_pixel(ACT_SEGMENT, 1005, 10, 20));
    queue_pixel(make_pixel(ACT_SEGMENT, 1200, 10, 20));
    queue_pixel(make_pixel(ACT_SEGMENT, 0, 10, 20));
    queue_pixel(make_pixel(ACT_SEGMENT, 1400, 10, 20));
    queue_pixel(make_pixel(ACT_SEGMENT, 601, 33, 44));
    queue_pixel(make_pixel(ACT_SEGMENT, 600, 33, 44));
    queue_random(380);
    wait_idle();

    // All registers at their largest, then at their most negative.
    for (int i = 0; i < 8; i++) write_coeff(reg_idx_t'(i), 32'h7fff_ffff);
    queue_random(300);
    wait_idle();
    for (int i = 0; i < 8; i++) write_coeff(reg_idx_t'(i), 32'h8000_0000);
    queue_random(300);
    wait_idle();

    // Small random gains around a plausible camera, so the box edges are
    // crossed by ordinary pixels.
    write_coeff(REG_X_COL, 32'($signed($urandom_range(2 ** 20)) - 2 ** 19));
    write_coeff(REG_X_ROW, 32'($signed($urandom_range(2 ** 20)) - 2 ** 19));
    write_coeff(REG_X_CONST, 32'($signed($urandom_range(2 ** 29)) - 2 ** 28));
    write_coeff(REG_X_OFF, 32'($signed($urandom_range(2000)) - 1000));
    write_coeff(REG_Z_COL, 32'($signed($urandom_range(2 ** 18)) - 2 ** 17));
    write_coeff(REG_Z_ROW, 32'($signed($urandom_range(2 ** 18)) - 2 ** 17));
    write_coeff(REG_Z_CONST, 32'h1000_0000 + $urandom_range(2 ** 26));
    write_coeff(REG_Z_OFF, 32'($signed($urandom_range(400)) - 200));
    queue_random(460);
    wait_idle();

    // Back to the straight camera with both sides running flat out.
    set_straight_camera();
    no_idle = 1'b1;
    queue_random(460);
    wait_idle();

    if (mismatches == 0 && owed_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
